### rtl/fcsg_pkg.sv
// Shared types and constants of the filled circle span generator.
package fcsg_pkg;

  localparam int MAX_RADIUS  = 63;
  localparam int MAX_RESULTS = 46;

  localparam int CoordW = 11;
  localparam int RadW   = 6;
  localparam int OutW   = 12;
  localparam int StepW  = 8;
  localparam int DecW   = 10;
  localparam int CntW   = $clog2(MAX_RESULTS);

  typedef struct packed {
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic        [RadW-1:0]   rad;
    logic signed [DecW-1:0]   dec0;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

### rtl/fcsg_front.sv
// Front end: accepts circle commands, clamps the radius and seeds the decision term.
module fcsg_front (
  input  logic                                center_valid,
  input  logic signed [fcsg_pkg::CoordW-1:0] center_x,
  input  logic signed [fcsg_pkg::CoordW-1:0] center_y,
  input  logic        [fcsg_pkg::RadW-1:0]   radius,
  input  fcsg_pkg::queue_status_t            q_status,
  output logic                                front_stall,
  output logic                                push,
  output fcsg_pkg::cmd_t                      push_cmd
);
  import fcsg_pkg::*;

  logic [RadW-1:0] rad_sat;

  always_comb begin
    if (int'(radius) > MAX_RADIUS) begin
      rad_sat = RadW'(MAX_RADIUS);
    end else begin
      rad_sat = radius;
    end
  end

  // The decision term starts at 3 - 2r.
  always_comb begin
    push_cmd.cx   = center_x;
    push_cmd.cy   = center_y;
    push_cmd.rad  = rad_sat;
    push_cmd.dec0 = DecW'(3) - DecW'({rad_sat, 1'b0});
  end

  assign front_stall = q_status.full;
  assign push        = center_valid && !q_status.full;

endmodule

### rtl/fcsg_queue.sv
// Two-entry command queue between the front end and the span engine.
module fcsg_queue (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  fcsg_pkg::cmd_t           push_cmd,
  input  logic                     pop,
  output fcsg_pkg::cmd_t           head_cmd,
  output fcsg_pkg::queue_status_t  status
);
  import fcsg_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assign head_cmd     = slots[rd_ptr];
  assign status.empty = (count == 2'd0);
  assign status.full  = (count == 2'd2);

endmodule

### rtl/fcsg_back.sv
// Span engine: runs the midpoint decision loop and registers one span set per step.
module fcsg_back (
  input  logic                              clk,
  input  logic                              rst,
  input  fcsg_pkg::cmd_t                    head_cmd,
  input  fcsg_pkg::queue_status_t           q_status,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fcsg_pkg::OutW-1:0] near_left,
  output logic signed [fcsg_pkg::OutW-1:0] near_right,
  output logic signed [fcsg_pkg::OutW-1:0] near_row_below,
  output logic signed [fcsg_pkg::OutW-1:0] near_row_above,
  output logic signed [fcsg_pkg::OutW-1:0] far_left,
  output logic signed [fcsg_pkg::OutW-1:0] far_right,
  output logic signed [fcsg_pkg::OutW-1:0] far_row_below,
  output logic signed [fcsg_pkg::OutW-1:0] far_row_above,
  output logic                              last
);
  import fcsg_pkg::*;

  typedef enum logic {IDLE, RUN} state_t;

  state_t                   state;
  logic signed [StepW-1:0]  step_x;
  logic signed [StepW-1:0]  step_y;
  logic signed [DecW-1:0]   decision;
  logic        [CntW-1:0]   count;
  logic signed [CoordW-1:0] held_cx;
  logic signed [CoordW-1:0] held_cy;

  logic signed [StepW-1:0]  step_x_next;
  logic signed [StepW-1:0]  step_y_next;
  logic signed [DecW-1:0]   decision_next;
  logic signed [StepW-1:0]  diff;
  logic                     fire;
  logic                     final_step;
  logic signed [OutW-1:0]   cx_w;
  logic signed [OutW-1:0]   cy_w;
  logic signed [OutW-1:0]   x_w;
  logic signed [OutW-1:0]   y_w;

  assign pop  = (state == IDLE) && !q_status.empty;
  assign fire = (state == RUN) && (!out_valid || !out_stall);

  always_comb begin
    diff        = step_x - step_y;
    step_x_next = step_x + StepW'(1);
    if (decision < 0) begin
      decision_next = decision + DecW'({step_x, 2'b00}) + DecW'(6);
      step_y_next   = step_y;
    end else begin
      decision_next = decision + DecW'({diff, 2'b00}) + DecW'(10);
      step_y_next   = step_y - StepW'(1);
    end
    final_step = (step_y_next < step_x_next) || (int'(count) == MAX_RESULTS - 1);
  end

  assign cx_w = OutW'(held_cx);
  assign cy_w = OutW'(held_cy);
  assign x_w  = OutW'(step_x);
  assign y_w  = OutW'(step_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      step_x    <= '0;
      step_y    <= '0;
      decision  <= '0;
      count     <= '0;
      held_cx   <= '0;
      held_cy   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (pop) begin
            state    <= RUN;
            step_x   <= '0;
            step_y   <= StepW'(head_cmd.rad);
            decision <= head_cmd.dec0;
            count    <= '0;
            held_cx  <= head_cmd.cx;
            held_cy  <= head_cmd.cy;
          end
        end
        RUN: begin
          if (fire) begin
            step_x   <= step_x_next;
            step_y   <= step_y_next;
            decision <= decision_next;
            count    <= count + CntW'(1);
            if (final_step) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase

      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      near_left      <= cx_w - x_w;
      near_right     <= cx_w + x_w;
      near_row_below <= cy_w + y_w;
      near_row_above <= cy_w - y_w;
      far_left       <= cx_w - y_w;
      far_right      <= cx_w + y_w;
      far_row_below  <= cy_w + x_w;
      far_row_above  <= cy_w - x_w;
      last           <= final_step;
    end
  end

endmodule

### rtl/filled_circle_span_generator.sv
// Top level of the filled circle span generator.
// Each accepted circle command (center_x, center_y, radius) yields a run of result
// transfers, one per step of the midpoint circle loop over the first octant; a radius r
// gives about r/sqrt(2) + 1 results (45 for the largest radius, one short of the cap of
// 46), and the final one carries last. The span engine produces one result per clock while
// out_stall is low, and returns to its idle state to take each next command from its queue.
// The front end clamps the radius and seeds the decision term, then hands the command to a
// two-entry queue, so up to two further commands are accepted while a circle is being
// drawn. Results sit in an output register that holds steady while out_stall is high.
module filled_circle_span_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [fcsg_pkg::CoordW-1:0] center_x,
  input  logic signed [fcsg_pkg::CoordW-1:0] center_y,
  input  logic        [fcsg_pkg::RadW-1:0]   radius,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [fcsg_pkg::OutW-1:0] near_left,
  output logic signed [fcsg_pkg::OutW-1:0] near_right,
  output logic signed [fcsg_pkg::OutW-1:0] near_row_below,
  output logic signed [fcsg_pkg::OutW-1:0] near_row_above,
  output logic signed [fcsg_pkg::OutW-1:0] far_left,
  output logic signed [fcsg_pkg::OutW-1:0] far_right,
  output logic signed [fcsg_pkg::OutW-1:0] far_row_below,
  output logic signed [fcsg_pkg::OutW-1:0] far_row_above,
  output logic                              last
);
  import fcsg_pkg::*;

  // Command handoff between the front end and the span engine.
  queue_status_t q_status;
  cmd_t          push_cmd;
  cmd_t          head_cmd;
  logic          push;
  logic          pop;

  // The front end stalls the input only when both queue slots are taken.
  fcsg_front u_front (
    .center_valid (in_valid),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius       (radius),
    .q_status     (q_status),
    .front_stall  (in_stall),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  fcsg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  // The span engine pops a command when idle and steps once per output transfer.
  fcsg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_cmd       (head_cmd),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .near_left      (near_left),
    .near_right     (near_right),
    .near_row_below (near_row_below),
    .near_row_above (near_row_above),
    .far_left       (far_left),
    .far_right      (far_right),
    .far_row_below  (far_row_below),
    .far_row_above  (far_row_above),
    .last           (last)
  );

endmodule

### rtl/fcsg_checker.sv
// Port-level checks of the filled circle span generator, bound to the top level.
module fcsg_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [fcsg_pkg::OutW-1:0] near_left,
  input logic signed [fcsg_pkg::OutW-1:0] near_right,
  input logic signed [fcsg_pkg::OutW-1:0] near_row_below,
  input logic signed [fcsg_pkg::OutW-1:0] near_row_above,
  input logic signed [fcsg_pkg::OutW-1:0] far_left,
  input logic signed [fcsg_pkg::OutW-1:0] far_right,
  input logic signed [fcsg_pkg::OutW-1:0] far_row_below,
  input logic signed [fcsg_pkg::OutW-1:0] far_row_above
);
  import fcsg_pkg::*;

  logic signed [OutW:0] near_col_sum;
  logic signed [OutW:0] far_col_sum;
  logic signed [OutW:0] near_row_sum;
  logic signed [OutW:0] far_row_sum;
  logic signed [OutW:0] near_width;
  logic signed [OutW:0] far_width;

  assign near_col_sum = (OutW+1)'(near_left) + (OutW+1)'(near_right);
  assign far_col_sum  = (OutW+1)'(far_left) + (OutW+1)'(far_right);
  assign near_row_sum = (OutW+1)'(near_row_below) + (OutW+1)'(near_row_above);
  assign far_row_sum  = (OutW+1)'(far_row_below) + (OutW+1)'(far_row_above);
  assign near_width   = (OutW+1)'(near_right) - (OutW+1)'(near_left);
  assign far_width    = (OutW+1)'(far_right) - (OutW+1)'(far_left);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(near_left) && $stable(far_row_above))
    else $error("stalled result changed");

  a_same_center_col: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> near_col_sum == far_col_sum)
    else $error("span pairs do not share a center column");

  a_same_center_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> near_row_sum == far_row_sum)
    else $error("span pairs do not share a center row");

  a_near_not_wider: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> near_width <= far_width && near_width >= 0)
    else $error("narrow span wider than wide span");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .near_left      (near_left),
  .near_right     (near_right),
  .near_row_below (near_row_below),
  .near_row_above (near_row_above),
  .far_left       (far_left),
  .far_right      (far_right),
  .far_row_below  (far_row_below),
  .far_row_above  (far_row_above)
);
